// ===== design/fsr_pkg.sv =====
package fsr_pkg;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned LEN_W  = 13;

  // segment kind carried in the frame header
  typedef enum logic [1:0] {
    SEG_SINGLE = 2'd0,
    SEG_START  = 2'd1,
    SEG_MORE   = 2'd2,
    SEG_END    = 2'd3
  } seg_kind_t;

  // kind of result word
  typedef enum logic [2:0] {
    KIND_DIRECT = 3'd0,
    KIND_DONE   = 3'd1,
    KIND_REJECT = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_READ   = 3'd4
  } out_kind_t;

  // one result word
  typedef struct packed {
    out_kind_t           kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    packet_length;
    logic [MAC_W-1:0]    sender;
    logic                last_direct;
  } result_t;

  // result in flight, data byte may still come from the buffer read port
  typedef struct packed {
    result_t res;
    logic    use_rdata;
  } pend_t;

endpackage

// ===== design/fsr_buf.sv =====
module fsr_buf #(
  parameter int unsigned PACKET_BYTES = 4096
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(PACKET_BYTES)-1:0]    wr_addr,
  input  logic [fsr_pkg::BYTE_W-1:0]         wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(PACKET_BYTES)-1:0]    rd_addr,
  output logic [fsr_pkg::BYTE_W-1:0]         rdata
);
  import fsr_pkg::*;

  logic [BYTE_W-1:0] mem [PACKET_BYTES];

  // packet byte store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fsr_ctrl.sv =====
module fsr_ctrl #(
  parameter int unsigned PACKET_BYTES = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               req_type,
  input  logic [fsr_pkg::MAC_W-1:0]          src_mac,
  input  logic [fsr_pkg::SEQ_W-1:0]          seq_num,
  input  logic [1:0]                         seg_kind,
  input  logic                               frame_ok,
  input  logic [fsr_pkg::BYTE_W-1:0]         payload_byte,
  input  logic                               first_of_frame,
  input  logic                               last_of_frame,
  input  logic [fsr_pkg::IDX_W-1:0]          read_index,
  output logic                               res_valid,
  output fsr_pkg::pend_t                     res,
  output logic                               wr_en,
  output logic [$clog2(PACKET_BYTES)-1:0]    wr_addr,
  output logic [fsr_pkg::BYTE_W-1:0]         wr_data,
  output logic                               rd_en,
  output logic [$clog2(PACKET_BYTES)-1:0]    rd_addr
);
  import fsr_pkg::*;

  localparam int unsigned AW   = $clog2(PACKET_BYTES);
  localparam int unsigned CW   = $clog2(PACKET_BYTES + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0]     fill_count, fill_count_next;
  logic [MAC_W-1:0]  stored_sender, stored_sender_next;
  logic [SEQ_W-1:0]  stored_seq, stored_seq_next;
  logic              skip_frame, skip_frame_next;
  seg_kind_t         kind_latch, kind_latch_next;

  seg_kind_t         in_kind;
  seg_kind_t         eff_kind;
  logic              cont_bad;
  logic              do_append;
  logic [CW-1:0]     fill_plus1;

  assign in_kind    = seg_kind_t'(seg_kind);
  assign fill_plus1 = fill_count + CW'(1);
  assign rd_addr    = AW'(read_index);
  assign wr_data    = payload_byte;

  // continuation check for more and end frames
  assign cont_bad = (src_mac != stored_sender) || (seq_num == '0) ||
                    (seq_num != stored_seq + SEQ_W'(1)) || (fill_count == '0);

  // frame decision and result
  always_comb begin
    fill_count_next    = fill_count;
    stored_sender_next = stored_sender;
    stored_seq_next    = stored_seq;
    skip_frame_next    = skip_frame;
    kind_latch_next    = kind_latch;
    res_valid          = 1'b0;
    res                = '0;
    rd_en              = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = fill_count[AW-1:0];
    do_append          = 1'b0;
    eff_kind           = first_of_frame ? in_kind : kind_latch;

    if (req_type) begin
      // buffer read
      rd_en         = accept;
      res_valid     = 1'b1;
      res.res.kind  = KIND_READ;
      res.use_rdata = CMPW'(read_index) < CMPW'(fill_count);
    end else if (first_of_frame && !frame_ok) begin
      kind_latch_next = in_kind;
      skip_frame_next = 1'b1;
      res_valid       = 1'b1;
      res.res.kind    = KIND_REJECT;
    end else if (first_of_frame && in_kind == SEG_START) begin
      // new packet, anything in progress is dropped
      kind_latch_next    = in_kind;
      skip_frame_next    = 1'b0;
      stored_sender_next = src_mac;
      stored_seq_next    = seq_num;
      wr_en              = accept;
      wr_addr            = '0;
      fill_count_next    = CW'(1);
      if (fill_count != '0) begin
        res_valid    = 1'b1;
        res.res.kind = KIND_DROP;
      end
    end else if (first_of_frame && in_kind != SEG_SINGLE && cont_bad) begin
      kind_latch_next = in_kind;
      skip_frame_next = 1'b1;
      res_valid       = 1'b1;
      res.res.kind    = KIND_REJECT;
    end else if (!first_of_frame &&
                 (skip_frame || (kind_latch != SEG_SINGLE && fill_count == '0))) begin
      // skipped or stray byte, nothing to do
      res_valid = 1'b0;
    end else begin
      if (first_of_frame) begin
        kind_latch_next = in_kind;
        skip_frame_next = 1'b0;
        if (in_kind == SEG_MORE) begin
          stored_seq_next = stored_seq + SEQ_W'(1);
        end
      end
      if (eff_kind == SEG_SINGLE) begin
        res_valid             = 1'b1;
        res.res.kind          = KIND_DIRECT;
        res.res.data_byte     = payload_byte;
        res.res.sender        = src_mac;
        res.res.last_direct   = last_of_frame;
      end else begin
        do_append = 1'b1;
      end
    end

    // append path with overflow and completion
    if (do_append) begin
      if (fill_count >= CW'(PACKET_BYTES)) begin
        fill_count_next = '0;
        skip_frame_next = 1'b1;
        res_valid       = 1'b1;
        res.res.kind    = KIND_REJECT;
      end else begin
        wr_en           = accept;
        fill_count_next = fill_plus1;
        if (eff_kind == SEG_END && last_of_frame) begin
          res_valid             = 1'b1;
          res.res.kind          = KIND_DONE;
          res.res.packet_length = LEN_W'(fill_plus1);
          res.res.sender        = stored_sender;
          fill_count_next       = '0;
          stored_seq_next       = '0;
        end
      end
    end
  end

  // assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      stored_sender <= '1;
      stored_seq    <= '0;
      skip_frame    <= 1'b0;
      kind_latch    <= SEG_SINGLE;
    end else if (accept) begin
      fill_count    <= fill_count_next;
      stored_sender <= stored_sender_next;
      stored_seq    <= stored_seq_next;
      skip_frame    <= skip_frame_next;
      kind_latch    <= kind_latch_next;
    end
  end

endmodule

// ===== design/fsr_outq.sv =====
module fsr_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        res_valid,
  input  fsr_pkg::pend_t              res,
  input  logic [fsr_pkg::BYTE_W-1:0]  rdata,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fsr_pkg::result_t            out_res
);
  import fsr_pkg::*;

  pend_t   s1;
  logic    s1_valid;
  result_t sk;
  logic    sk_valid;
  logic    o_valid;
  result_t s1_final;
  logic    o_free;
  logic    sk_to_o;
  logic    s1_to_o;
  logic    s1_to_sk;

  // read data joins the result once the buffer port has answered
  always_comb begin
    s1_final = s1.res;
    if (s1.use_rdata) begin
      s1_final.data_byte = rdata;
    end
  end

  assign o_free   = !o_valid || out_ready;
  assign sk_to_o  = o_free && sk_valid;
  assign s1_to_o  = o_free && !sk_valid && s1_valid;
  assign s1_to_sk = s1_valid && !s1_to_o && (!sk_valid || sk_to_o);
  assign in_ready = !sk_valid;
  assign out_valid = o_valid;

  // valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      sk_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= res_valid;
      end else if (s1_to_o || s1_to_sk) begin
        s1_valid <= 1'b0;
      end
      if (s1_to_sk) begin
        sk_valid <= 1'b1;
      end else if (sk_to_o) begin
        sk_valid <= 1'b0;
      end
      if (o_free) begin
        o_valid <= sk_valid || s1_valid;
      end
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= res;
    end
    if (s1_to_sk) begin
      sk <= s1_final;
    end
    if (sk_to_o) begin
      out_res <= sk;
    end else if (s1_to_o) begin
      out_res <= s1_final;
    end
  end

endmodule

// ===== design/frame_segment_reassembler.sv =====
// Frame segment reassembler. Takes one word per cycle on the slave stream:
// frame payload bytes tagged with sender, sequence, segment kind and check
// flag, or read requests into the assembled packet. Single-frame bytes pass
// straight through; start, more and end frames are gathered in a packet
// buffer of PACKET_BYTES bytes and the last byte of an end frame reports the
// length. A new word is accepted every cycle while the skid is not full;
// each result passes the read stage, where the registered buffer read data
// joins it, and then the output register. A one-entry skid behind the read
// stage lets input go on while a result waits; s_tready drops only when that skid is full.
module frame_segment_reassembler #(
  parameter int unsigned PACKET_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_mac[47:0], seq_num[63:48], payload_byte[71:64], first_of_frame[72],
  // read_index[84:73], zero fill [87:85]
  input  logic [87:0]  s_tdata,
  // req_type[0], seg_kind[2:1], frame_ok[3]
  input  logic [3:0]   s_tuser,
  // last_of_frame
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // data_byte[7:0], packet_length[20:8], sender[68:21], zero fill [71:69]
  output logic [71:0]  m_tdata,
  // out_kind[2:0]
  output logic [2:0]   m_tuser,
  // last_direct
  output logic         m_tlast
);
  import fsr_pkg::*;

  localparam int unsigned AW = $clog2(PACKET_BYTES);

  logic              accept;
  logic              res_valid;
  pend_t             res;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rdata;
  result_t           out_res;

  assign accept = s_tvalid && s_tready;

  // frame decisions and assembly state
  fsr_ctrl #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .req_type       (s_tuser[0]),
    .src_mac        (s_tdata[47:0]),
    .seq_num        (s_tdata[63:48]),
    .seg_kind       (s_tuser[2:1]),
    .frame_ok       (s_tuser[3]),
    .payload_byte   (s_tdata[71:64]),
    .first_of_frame (s_tdata[72]),
    .last_of_frame  (s_tlast),
    .read_index     (s_tdata[84:73]),
    .res_valid      (res_valid),
    .res            (res),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr)
  );

  // packet buffer
  fsr_buf #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rdata   (rdata)
  );

  // read stage, skid and output register
  fsr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .rdata     (rdata),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // output word packing
  assign m_tdata = {3'b000, out_res.sender, out_res.packet_length, out_res.data_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last_direct;

endmodule

// ===== tb/sv/frame_segment_reassembler_test.sv =====
`timescale 1ns / 1ps

module frame_segment_reassembler_test;
  import fsr_pkg::*;

  localparam int PACKET_BYTES = 4096;
  localparam int RANDOM_WORDS = 1700;
  localparam int QUIET_WORDS  = 300;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 20;

  localparam logic [MAC_W-1:0] MAC_A = 48'h0123_4567_89AB;
  localparam logic [MAC_W-1:0] MAC_B = 48'hFEDC_BA98_7654;

  // one input word, unpacked
  typedef struct {
    logic              req;
    logic [MAC_W-1:0]  mac;
    logic [SEQ_W-1:0]  seq;
    seg_kind_t         kind;
    logic              ok;
    logic [BYTE_W-1:0] payload;
    logic              sof;
    logic              eof;
    logic [IDX_W-1:0]  idx;
  } in_word_t;

  // reassembly predictor plus the queue of results still due
  class reassembly_scoreboard;
    logic [BYTE_W-1:0] pkt_mem [PACKET_BYTES];
    logic [LEN_W-1:0]  fill;
    logic [MAC_W-1:0]  owner;
    logic [SEQ_W-1:0]  last_seq;
    bit                skip;
    seg_kind_t         latch;
    result_t           awaited[$];
    int                errors;
    int                seen[5];

    function new();
      fill     = '0;
      owner    = '1;
      last_seq = '0;
      skip     = 1'b0;
      latch    = SEG_SINGLE;
      errors   = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void queue_result(out_kind_t k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] len,
                               logic [MAC_W-1:0] snd, logic ld);
      result_t r;
      r.kind          = k;
      r.data_byte     = d;
      r.packet_length = len;
      r.sender        = snd;
      r.last_direct   = ld;
      awaited.push_back(r);
    endfunction

    // append to the packet, overflow drops it and skips the frame
    function bit append(logic [BYTE_W-1:0] b);
      if (fill >= PACKET_BYTES) begin
        fill = '0;
        skip = 1'b1;
        return 1'b0;
      end
      pkt_mem[fill] = b;
      fill++;
      return 1'b1;
    endfunction

    // called once per accepted input word
    function void note_word(in_word_t w);
      if (w.req) begin
        queue_result(KIND_READ, (w.idx < fill) ? pkt_mem[w.idx] : '0, '0, '0, 1'b0);
        return;
      end
      if (w.sof) begin
        latch = w.kind;
        skip  = 1'b0;
        if (!w.ok) begin
          skip = 1'b1;
          queue_result(KIND_REJECT, '0, '0, '0, 1'b0);
          return;
        end
        if (w.kind == SEG_START) begin
          if (fill != 0) begin
            fill = '0;
            queue_result(KIND_DROP, '0, '0, '0, 1'b0);
          end
          owner    = w.mac;
          last_seq = w.seq;
          void'(append(w.payload));
          return;
        end
        if (w.kind == SEG_MORE || w.kind == SEG_END) begin
          // continuation must match sender and next sequence, with a packet open
          if (w.mac != owner || w.seq == 0 || last_seq != w.seq - 16'd1 || fill == 0) begin
            skip = 1'b1;
            queue_result(KIND_REJECT, '0, '0, '0, 1'b0);
            return;
          end
          if (w.kind == SEG_MORE) last_seq = last_seq + 16'd1;
        end
      end else begin
        if (skip) return;
        if (latch != SEG_SINGLE && fill == 0) return;
      end
      if (latch == SEG_SINGLE) begin
        queue_result(KIND_DIRECT, w.payload, '0, w.mac, w.eof);
        return;
      end
      if (!append(w.payload)) begin
        queue_result(KIND_REJECT, '0, '0, '0, 1'b0);
        return;
      end
      if (latch == SEG_END && w.eof) begin
        queue_result(KIND_DONE, '0, fill, owner, 1'b0);
        fill     = '0;
        last_seq = '0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // called once per accepted result word
    function void check_word(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("result word with no expectation: kind %0d", got.kind);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (int'(want.kind) < 5) seen[want.kind]++;
      compare_field("out_kind", 64'(want.kind), 64'(got.kind));
      compare_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
      compare_field("packet_length", 64'(want.packet_length), 64'(got.packet_length));
      compare_field("sender", 64'(want.sender), 64'(got.sender));
      compare_field("last_direct", 64'(want.last_direct), 64'(got.last_direct));
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [87:0]           s_tdata = '0;
  logic [3:0]            s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [71:0]           m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;

  reassembly_scoreboard  sb = new();
  logic [MAC_W-1:0]      senders[4];
  bit                    quiet = 1'b0;
  int                    stall_left = 0;
  int                    idle_cycles = 0;
  int                    words_sent = 0;

  frame_segment_reassembler #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls in bursts, none in the quiet tail
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rst && !quiet && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind          = out_kind_t'(m_tuser);
      got.data_byte     = m_tdata[7:0];
      got.packet_length = m_tdata[20:8];
      got.sender        = m_tdata[68:21];
      got.last_direct   = m_tlast;
      sb.check_word(got);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("frame_segment_reassembler regression: fail");
      $finish;
    end
  end

  function automatic in_word_t any_word();
    in_word_t w;
    w.req     = 1'b0;
    w.mac     = MAC_W'({$urandom, $urandom});
    w.seq     = SEQ_W'($urandom);
    w.kind    = seg_kind_t'($urandom_range(0, 3));
    w.ok      = 1'($urandom_range(0, 1));
    w.payload = BYTE_W'($urandom);
    w.sof     = 1'($urandom_range(0, 1));
    w.eof     = 1'($urandom_range(0, 1));
    w.idx     = IDX_W'($urandom);
    return w;
  endfunction

  function automatic logic [MAC_W-1:0] pick_sender();
    if ($urandom_range(0, 4) == 0) return MAC_W'({$urandom, $urandom});
    return senders[$urandom_range(0, 3)];
  endfunction

  // drive one word at the falling edge and hold it until accepted
  task automatic put_word(input in_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, w.idx, w.sof, w.payload, w.seq, w.mac};
    s_tuser  <= {w.ok, w.kind, w.req};
    s_tlast  <= w.eof;
    do @(posedge clk); while (!s_tready);
    sb.note_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  // header fields of later bytes are noise the block must ignore
  task automatic send_frame(input seg_kind_t k, input logic [MAC_W-1:0] mac,
                            input logic [SEQ_W-1:0] seq, input bit ok, input int len);
    in_word_t w;
    for (int i = 0; i < len; i++) begin
      w     = any_word();
      w.mac = mac;
      w.sof = (i == 0);
      w.eof = (i == len - 1);
      if (i == 0 || $urandom_range(0, 1) == 1) begin
        w.kind = k;
        w.seq  = seq;
        w.ok   = ok;
      end
      put_word(w);
    end
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    in_word_t w;
    w     = any_word();
    w.req = 1'b1;
    w.idx = idx;
    put_word(w);
  endtask

  // start, up to three more frames, end; with the odd broken frame in between
  task automatic send_packet();
    logic [MAC_W-1:0] mac;
    logic [SEQ_W-1:0] seq;
    int               more_frames;
    seg_kind_t        k;
    mac = pick_sender();
    seq = ($urandom_range(0, 3) == 0) ? SEQ_W'($urandom) : SEQ_W'($urandom_range(0, 16'hFF00));
    more_frames = $urandom_range(0, 3);
    send_frame(SEG_START, mac, seq, 1'b1, $urandom_range(1, 8));
    for (int i = 0; i <= more_frames; i++) begin
      k = (i == more_frames) ? SEG_END : SEG_MORE;
      seq = seq + 16'd1;
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          send_read(IDX_W'($urandom_range(0, sb.fill)));
        end else begin
          send_frame(SEG_SINGLE, pick_sender(), SEQ_W'($urandom), 1'b1,
                     $urandom_range(1, 3));
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: send_frame(k, mac ^ (48'h1 << $urandom_range(0, 47)), seq, 1'b1, 2);
          1: send_frame(k, mac, seq + SEQ_W'($urandom_range(1, 16'hFFFE)), 1'b1, 2);
          default: send_frame(k, mac, seq, 1'b0, 2);
        endcase
      end
      send_frame(k, mac, seq, 1'b1, $urandom_range(1, 8));
    end
  endtask

  initial begin
    in_word_t w;
    int       pick;
    int       random_start;

    senders[0] = '1;
    senders[1] = '0;
    senders[2] = MAC_W'({$urandom, $urandom});
    senders[3] = MAC_W'({$urandom, $urandom});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stray byte right after reset acts as a single-frame byte
    w         = any_word();
    w.sof     = 1'b0;
    w.eof     = 1'b0;
    w.mac     = '0;
    w.payload = 8'h00;
    put_word(w);
    // two-byte single frame from the broadcast sender
    w         = any_word();
    w.sof     = 1'b1;
    w.eof     = 1'b0;
    w.kind    = SEG_SINGLE;
    w.ok      = 1'b1;
    w.mac     = '1;
    w.payload = 8'hFF;
    put_word(w);
    w.sof     = 1'b0;
    w.eof     = 1'b1;
    w.payload = 8'h00;
    put_word(w);
    // bad frame, its second byte is skipped
    send_frame(SEG_START, MAC_A, 16'h0010, 1'b0, 2);
    // continuation with no packet open
    send_frame(SEG_MORE, MAC_A, 16'h0001, 1'b1, 1);
    send_frame(SEG_START, MAC_A, 16'hFFFE, 1'b1, 2);
    send_read(12'd0);
    send_read(12'd1);
    send_read(12'd2);
    send_read(12'hFFF);
    // wrong sender, then wrong sequence
    send_frame(SEG_MORE, MAC_B, 16'hFFFF, 1'b1, 1);
    send_frame(SEG_MORE, MAC_A, 16'h0005, 1'b1, 1);
    send_frame(SEG_MORE, MAC_A, 16'hFFFF, 1'b1, 1);
    // sequence zero never continues
    send_frame(SEG_END, MAC_A, 16'h0000, 1'b1, 1);
    // start over an open packet drops it
    send_frame(SEG_START, MAC_B, 16'h0000, 1'b1, 1);
    send_frame(SEG_END, MAC_B, 16'h0001, 1'b1, 2);
    // read after done, then a stray byte of the finished frame
    send_read(12'd0);
    w     = any_word();
    w.sof = 1'b0;
    put_word(w);
    send_frame(SEG_END, MAC_B, 16'h0002, 1'b1, 1);
    send_frame(SEG_START, '0, 16'h0007, 1'b1, 1);
    send_frame(SEG_END, '0, 16'h0008, 1'b1, 1);

    // random traffic, mostly well-formed packets
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      quiet = (words_sent - random_start >= RANDOM_WORDS - QUIET_WORDS);
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
        send_packet();
      end else if (pick < 60) begin
        send_frame(SEG_SINGLE, pick_sender(), SEQ_W'($urandom), 1'b1, $urandom_range(1, 6));
      end else if (pick < 72) begin
        if (sb.fill != 0 && $urandom_range(0, 1) == 1) begin
          send_read(IDX_W'($urandom_range(0, sb.fill)));
        end else begin
          send_read(IDX_W'($urandom));
        end
      end else if (pick < 90) begin
        send_frame(seg_kind_t'($urandom_range(0, 3)), pick_sender(),
                   ($urandom_range(0, 1) == 1) ? sb.last_seq + 16'd1 : SEQ_W'($urandom),
                   $urandom_range(0, 3) != 0, $urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          w     = any_word();
          w.sof = 1'b0;
          put_word(w);
        end
      end
    end
    s_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d input words, %0d of them in the directed corner-case phase",
             words_sent, random_start);
    $display("checked: %0d direct, %0d done, %0d rejected, %0d dropped, %0d reads",
             sb.seen[KIND_DIRECT], sb.seen[KIND_DONE], sb.seen[KIND_REJECT],
             sb.seen[KIND_DROP], sb.seen[KIND_READ]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("frame_segment_reassembler regression: pass");
    end else begin
      $display("frame_segment_reassembler regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fsr_pkg.sv
design/fsr_buf.sv
design/fsr_ctrl.sv
design/fsr_outq.sv
design/frame_segment_reassembler.sv
tb/sv/frame_segment_reassembler_test.sv
